/* sv/btms_pkg.sv */
// types, constants and register defaults for the button timed mode sequencer
`default_nettype none

package btms_pkg;

   typedef enum logic [2:0] {
      MODE_EYES     = 3'd0,
      MODE_CLOCK    = 3'd1,
      MODE_WEATHER  = 3'd2,
      MODE_POMODORO = 3'd3,
      MODE_STATS    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      PRESS_NONE  = 2'd0,
      PRESS_SHORT = 2'd1,
      PRESS_LONG  = 2'd2
   } press_type;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_EYES_DWELL    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_DWELL   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEATHER_DWELL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_PRESS   = 3'd4;

   localparam logic [31:0] DWELL_RESET       = 32'd10000;
   localparam logic [15:0] LONG_PRESS_RESET  = 16'd800;
   localparam logic [15:0] SHORT_PRESS_RESET = 16'd200;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        button_pressed;
   } req_type;

   typedef struct packed {
      logic        long_press;
      logic        short_press;
      logic [2:0]  shown_mode;
      logic        mode_changed;
   } rsp_type;

   // classified tick handed from front to back
   typedef struct packed {
      logic [31:0] now_ms;
      press_type   press;
   } evt_type;

   typedef struct packed {
      logic [31:0] eyes_dwell_ms;
      logic [31:0] clock_dwell_ms;
      logic [31:0] weather_dwell_ms;
      logic [15:0] long_press_ms;
      logic [15:0] short_press_ms;
   } cfg_type;

endpackage

`default_nettype wire

/* sv/btms_front.sv */
// front end: press edge tracking and hold classification
`default_nettype none

module btms_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire btms_pkg::req_type  req_data,
   input  wire logic [15:0]        long_press_ms,
   input  wire logic [15:0]        short_press_ms,
   output btms_pkg::evt_type       evt
);

   logic        held_ff;
   logic        held_in;
   logic [31:0] start_ff;
   logic [31:0] start_in;
   logic [31:0] hold_time;

   assign hold_time = req_data.now_ms - start_ff;

   always_comb begin
      held_in    = held_ff;
      start_in   = start_ff;
      evt.now_ms = req_data.now_ms;
      evt.press  = btms_pkg::PRESS_NONE;
      if (req_data.button_pressed && !held_ff) begin
         held_in  = 1'b1;
         start_in = req_data.now_ms;
      end
      if (!req_data.button_pressed && held_ff) begin
         held_in = 1'b0;
         if (hold_time >= {16'd0, long_press_ms}) begin
            evt.press = btms_pkg::PRESS_LONG;
         end else if (hold_time >= {16'd0, short_press_ms}) begin
            evt.press = btms_pkg::PRESS_SHORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         start_ff <= 32'd0;
      end else if (push) begin
         held_ff  <= held_in;
         start_ff <= start_in;
      end
   end

endmodule

`default_nettype wire

/* sv/btms_queue.sv */
// two entry queue between front and back
`default_nettype none

module btms_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire btms_pkg::evt_type  push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    pop_valid,
   output btms_pkg::evt_type       pop_data
);

   btms_pkg::evt_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* sv/btms_back.sv */
// back end: mode sequencing, dwell timing and result register
`default_nettype none

module btms_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               evt_valid,
   input  wire btms_pkg::evt_type  evt,
   output logic                    pop,
   input  wire logic [31:0]        eyes_dwell_ms,
   input  wire logic [31:0]        clock_dwell_ms,
   input  wire logic [31:0]        weather_dwell_ms,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output btms_pkg::rsp_type       rsp_data
);

   btms_pkg::mode_type mode_ff;
   btms_pkg::mode_type mode_in;
   logic [31:0]        entry_ff;
   logic [31:0]        entry_in;
   logic               pend_ff;
   logic               pend_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   btms_pkg::rsp_type  rsp_ff;
   btms_pkg::rsp_type  rsp_in;
   logic               press_chg;
   logic               auto_chg;
   logic [31:0]        dwell;
   logic [31:0]        elapsed;
   btms_pkg::mode_type cyc_next;

   assign pop       = evt_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign elapsed   = evt.now_ms - entry_ff;

   always_comb begin
      unique case (mode_ff)
         btms_pkg::MODE_EYES: begin
            dwell    = eyes_dwell_ms;
            cyc_next = btms_pkg::MODE_CLOCK;
         end
         btms_pkg::MODE_CLOCK: begin
            dwell    = clock_dwell_ms;
            cyc_next = btms_pkg::MODE_WEATHER;
         end
         btms_pkg::MODE_WEATHER: begin
            dwell    = weather_dwell_ms;
            cyc_next = btms_pkg::MODE_EYES;
         end
         default: begin
            dwell    = 32'd0;
            cyc_next = btms_pkg::MODE_EYES;
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      entry_in  = entry_ff;
      press_chg = 1'b0;
      unique case (evt.press)
         btms_pkg::PRESS_LONG: begin
            if (mode_ff == btms_pkg::MODE_EYES) begin
               mode_in   = btms_pkg::MODE_POMODORO;
               press_chg = 1'b1;
            end else if (mode_ff == btms_pkg::MODE_CLOCK ||
                         mode_ff == btms_pkg::MODE_WEATHER) begin
               mode_in   = btms_pkg::MODE_STATS;
               press_chg = 1'b1;
            end
         end
         btms_pkg::PRESS_SHORT: begin
            if (mode_ff == btms_pkg::MODE_STATS) begin
               mode_in   = btms_pkg::MODE_EYES;
               press_chg = 1'b1;
            end else if (mode_ff != btms_pkg::MODE_POMODORO) begin
               mode_in   = cyc_next;
               press_chg = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // a press that moved the mode restarts the dwell, so no advance this beat
      auto_chg = !press_chg && (dwell != 32'd0) && (elapsed >= dwell);
      if (auto_chg) begin
         mode_in = cyc_next;
      end
      if (press_chg || auto_chg) begin
         entry_in = evt.now_ms;
      end
      pend_in             = 1'b0;
      rsp_in.long_press   = (evt.press == btms_pkg::PRESS_LONG);
      rsp_in.short_press  = (evt.press == btms_pkg::PRESS_SHORT);
      rsp_in.shown_mode   = mode_in;
      rsp_in.mode_changed = pend_ff || press_chg || auto_chg;
      rsp_valid_in        = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= btms_pkg::MODE_EYES;
         entry_ff     <= 32'd0;
         pend_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            mode_ff  <= mode_in;
            entry_ff <= entry_in;
            pend_ff  <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.long_press && rsp_ff.short_press))
      else $error("long and short press in one beat");
   a_change_reported: assert property (@(posedge clock) disable iff (reset)
      pop && (mode_in != mode_ff) |=> rsp_ff.mode_changed)
      else $error("mode change not flagged");
   a_mode_matches: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_ff.shown_mode == mode_ff)
      else $error("reported mode differs from held mode");
   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      pop |=> !pend_ff)
      else $error("change flag not cleared after report");
`endif

endmodule

`default_nettype wire

/* sv/button_timed_mode_sequencer.sv */
// top level: control registers, front end, queue and back end
// path: a beat goes through a queue entry and then the back end output register
// throughput: one beat per cycle unless rsp_stall holds it, limited by the mode
// update in the back end; the two entry queue lets either side stall alone
// reset: synchronous; clears the queue, output valid flag and mode state
// (eyes, change flag set) and loads the default control registers
`default_nettype none

module button_timed_mode_sequencer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire btms_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output btms_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [btms_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [31:0]                          csr_wdata
);

   btms_pkg::cfg_type cfg_ff;
   btms_pkg::cfg_type cfg_in;
   btms_pkg::evt_type front_evt;
   btms_pkg::evt_type back_evt;
   logic              push;
   logic              full;
   logic              pop;
   logic              evt_valid;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign push      = req_valid && !full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            btms_pkg::CSR_EYES_DWELL:    cfg_in.eyes_dwell_ms    = csr_wdata;
            btms_pkg::CSR_CLOCK_DWELL:   cfg_in.clock_dwell_ms   = csr_wdata;
            btms_pkg::CSR_WEATHER_DWELL: cfg_in.weather_dwell_ms = csr_wdata;
            btms_pkg::CSR_LONG_PRESS:    cfg_in.long_press_ms    = csr_wdata[15:0];
            btms_pkg::CSR_SHORT_PRESS:   cfg_in.short_press_ms   = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eyes_dwell_ms    <= btms_pkg::DWELL_RESET;
         cfg_ff.clock_dwell_ms   <= btms_pkg::DWELL_RESET;
         cfg_ff.weather_dwell_ms <= btms_pkg::DWELL_RESET;
         cfg_ff.long_press_ms    <= btms_pkg::LONG_PRESS_RESET;
         cfg_ff.short_press_ms   <= btms_pkg::SHORT_PRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   btms_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .req_data       (req_data),
      .long_press_ms  (cfg_ff.long_press_ms),
      .short_press_ms (cfg_ff.short_press_ms),
      .evt            (front_evt)
   );

   btms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_evt),
      .full      (full),
      .pop       (pop),
      .pop_valid (evt_valid),
      .pop_data  (back_evt)
   );

   btms_back u_back (
      .clock            (clock),
      .reset            (reset),
      .evt_valid        (evt_valid),
      .evt              (back_evt),
      .pop              (pop),
      .eyes_dwell_ms    (cfg_ff.eyes_dwell_ms),
      .clock_dwell_ms   (cfg_ff.clock_dwell_ms),
      .weather_dwell_ms (cfg_ff.weather_dwell_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

`default_nettype wire
